### design/positional_list_engine_unit_assert.svh
// Assertion macros used by the checker of the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH

// Concurrent assertion on clk_i, switched off while rst_ni is low.
`define PLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication to the next cycle, same clock and reset.
`define PLE_ASSERT_NEXT(name, pre, post, msg) \
  `PLE_ASSERT(name, (pre) |=> (post), msg)

`endif

### design/ple_pkg.sv
// Package of the positional list engine: item types, codes and constants.
package ple_pkg;

  localparam int unsigned DefaultCapacity = 64;
  // Cell index width that covers the largest supported capacity.
  localparam int unsigned MaxIdxW = 10;
  localparam int unsigned WordW = 32;
  localparam int unsigned PosW = 7;
  localparam int unsigned OutCntW = 7;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_READ      = 3'd6,
    OP_WRITE     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_REMOVE,
    ACT_WRITE
  } act_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e                     op;
    logic [PosW-1:0]         position;
    logic signed [WordW-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic signed [WordW-1:0] read_value;
    logic [OutCntW-1:0]      item_count;
    logic signed [WordW-1:0] front_value;
    logic signed [WordW-1:0] back_value;
  } out_item_t;

  // Broadcast to every cell: what to do and where.
  typedef struct packed {
    act_e               act;
    logic [MaxIdxW-1:0] at;
  } cell_cmd_t;

  // Read taps: the requested position and the last entry.
  typedef struct packed {
    logic [MaxIdxW-1:0] rd_at;
    logic [MaxIdxW-1:0] bk_at;
  } tap_sel_t;

endpackage

### design/ple_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
interface ple_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/positional_list_engine_unit.sv
// Top level of the positional list engine: sequencer, count and the row of cells.
//
// Usage:
//   in_i carries one operation per beat (op, position, value); out_o returns
//   exactly one result beat per operation (status, read_value, item_count,
//   front_value, back_value).
//   An operation is accepted in the idle state. At the accepting edge every
//   cell shifts, loads or holds at once, so an insert or remove at any position
//   moves the whole tail in one step. In the cycle after the accept the read
//   taps of the cells are OR-combined and the result register is loaded.
//   The result beat is presented in the output state, which follows the gather state.
//   A new operation is taken only once the result beat of the last one is taken,
//   set by the accept / gather / present sequence around the cell row.
//   Reset clears the entry count and the sequencer; entry contents are
//   undefined until written, and only entries below the count are ever read.
//   While the receiver stalls the result beat holds and no new input beat is
//   taken.
module positional_list_engine_unit #(
  parameter int unsigned Capacity = ple_pkg::DefaultCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ple_stream_if.sink        in_i,
  ple_stream_if.source      out_o
);
  import ple_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  status_e stat_q, stat_d;
  logic is_read_q;
  logic [MaxIdxW-1:0] rd_at_q;
  out_item_t out_q;

  logic in_fire, load_out;
  act_e act;
  logic [CmpW-1:0] cnt_w, pos_w, at_w;
  cell_cmd_t cmd;
  tap_sel_t sel;

  word_t cell_data [Capacity];
  word_t rd_tap    [Capacity];
  word_t bk_tap    [Capacity];
  word_t rd_bus, bk_bus;

  // Decode the operation against the current count
  always_comb begin
    cnt_w  = CmpW'(count_q);
    pos_w  = CmpW'(in_i.data.position);
    at_w   = '0;
    act    = ACT_HOLD;
    stat_d = STAT_OK;
    unique case (in_i.data.op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (in_i.data.op == OP_INS_FRONT) at_w = '0;
        else if (in_i.data.op == OP_INS_BACK) at_w = cnt_w;
        else at_w = pos_w;
        if (at_w > cnt_w) stat_d = STAT_BAD;
        else if (count_q == CntW'(Capacity)) stat_d = STAT_FULL;
        else act = ACT_INSERT;
      end
      OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
        if (in_i.data.op == OP_REM_FRONT) at_w = '0;
        else if (in_i.data.op == OP_REM_BACK) at_w = cnt_w - CmpW'(1);
        else at_w = pos_w;
        if (count_q == '0 || at_w >= cnt_w) stat_d = STAT_BAD;
        else act = ACT_REMOVE;
      end
      OP_READ: begin
        at_w = pos_w;
        if (pos_w >= cnt_w) stat_d = STAT_BAD;
      end
      OP_WRITE: begin
        at_w = pos_w;
        if (pos_w >= cnt_w) stat_d = STAT_BAD;
        else act = ACT_WRITE;
      end
    endcase
  end

  assign in_fire = in_i.valid && in_i.ready;
  assign cmd.act = in_fire ? act : ACT_HOLD;
  assign cmd.at  = MaxIdxW'(at_w);

  always_comb begin
    count_d = count_q;
    if (cmd.act == ACT_INSERT) count_d = count_q + CntW'(1);
    else if (cmd.act == ACT_REMOVE) count_d = count_q - CntW'(1);
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    out_o.valid = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) state_d = S_GATHER;
      end
      S_GATHER: begin
        load_out = 1'b1;
        state_d  = S_OUT;
      end
      S_OUT: begin
        out_o.valid = 1'b1;
        if (out_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stat_q    <= stat_d;
      is_read_q <= (in_i.data.op == OP_READ);
      rd_at_q   <= MaxIdxW'(pos_w);
    end
  end

  // Row of cells
  assign sel.rd_at = rd_at_q;
  assign sel.bk_at = MaxIdxW'(count_q - CntW'(1));

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    word_t left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    ple_cell #(
      .CellIdx (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .value_i (in_i.data.value),
      .left_i  (left),
      .right_i (right),
      .sel_i   (sel),
      .data_o  (cell_data[i]),
      .rd_o    (rd_tap[i]),
      .bk_o    (bk_tap[i])
    );
  end

  always_comb begin
    rd_bus = '0;
    bk_bus = '0;
    for (int unsigned i = 0; i < Capacity; i++) begin
      rd_bus = rd_bus | rd_tap[i];
      bk_bus = bk_bus | bk_tap[i];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.status      <= stat_q;
      out_q.read_value  <= (is_read_q && stat_q == STAT_OK) ? rd_bus : '0;
      out_q.item_count  <= OutCntW'(count_q);
      out_q.front_value <= (count_q != '0) ? cell_data[0] : '0;
      out_q.back_value  <= (count_q != '0) ? bk_bus : '0;
    end
  end

  assign out_o.data = out_q;

endmodule

### design/ple_cell.sv
// One list cell: holds an entry, shifts to or from its neighbours, drives read taps.
module ple_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic               clk_i,
  input  ple_pkg::cell_cmd_t cmd_i,
  input  ple_pkg::word_t     value_i,
  input  ple_pkg::word_t     left_i,
  input  ple_pkg::word_t     right_i,
  input  ple_pkg::tap_sel_t  sel_i,
  output ple_pkg::word_t     data_o,
  output ple_pkg::word_t     rd_o,
  output ple_pkg::word_t     bk_o
);
  import ple_pkg::*;

  localparam logic [MaxIdxW-1:0] Idx = MaxIdxW'(CellIdx);

  word_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.act)
      ACT_INSERT: begin
        if (Idx > cmd_i.at) data_d = left_i;
        else if (Idx == cmd_i.at) data_d = value_i;
      end
      ACT_REMOVE: begin
        if (Idx >= cmd_i.at) data_d = right_i;
      end
      ACT_WRITE: begin
        if (Idx == cmd_i.at) data_d = value_i;
      end
      ACT_HOLD: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (Idx == sel_i.rd_at) ? data_q : '0;
  assign bk_o   = (Idx == sel_i.bk_at) ? data_q : '0;

endmodule

### design/ple_checker.sv
// Port-level checker for the positional list engine, bound to the top level.
`include "positional_list_engine_unit_assert.svh"

module ple_checker #(
  parameter int unsigned Capacity = ple_pkg::DefaultCapacity
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input ple_pkg::out_item_t out_data_i
);
  import ple_pkg::*;

  `PLE_ASSERT(a_no_accept_while_pending, out_valid_i |-> !in_ready_i, "input taken while a result beat is pending")
  `PLE_ASSERT(a_result_follows, (in_valid_i && in_ready_i) |-> ##2 out_valid_i, "result beat not presented two cycles after accept")
  `PLE_ASSERT(a_full_count, (out_valid_i && out_data_i.status == STAT_FULL) |-> (out_data_i.item_count == OutCntW'(Capacity)), "full status with a count short of capacity")
  `PLE_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "stalled result beat dropped or changed")

endmodule

bind positional_list_engine_unit ple_checker #(
  .Capacity (Capacity)
) u_ple_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
